// ===== rtl/core/nearest_seed_voronoi_labeler_defines.svh =====
// ----------------------------------------------------------------------------
// nearest seed voronoi labeler: assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef NEAREST_SEED_VORONOI_LABELER_DEFINES_SVH
`define NEAREST_SEED_VORONOI_LABELER_DEFINES_SVH

// property must hold at every edge outside reset
`define NSVL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nsvl port check failed");

// condition must never be seen outside reset
`define NSVL_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("nsvl forbidden condition seen");

`endif

// ===== rtl/core/nsvl_pkg.sv =====
// ----------------------------------------------------------------------------
// nsvl_pkg
// types and fixed field layout of the nearest seed voronoi labeler
// ----------------------------------------------------------------------------
package nsvl_pkg;

  // item kinds carried on the input tuser bit
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // fixed field widths
  localparam int SLOT_W  = 8;
  localparam int FIELD_W = 16;
  localparam int COUNT_W = 9;
  localparam int ID_W    = 9;
  localparam int DIST_W  = 33;

  // input tdata layout: seed_index, coord_x, coord_y
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_X_LSB    = IN_SLOT_LSB + SLOT_W;
  localparam int IN_Y_LSB    = IN_X_LSB + FIELD_W;
  localparam int IN_DATA_W   = 40;

  // output tdata layout: nearest_id, min_distance, zero fill
  localparam int OUT_ID_LSB   = 0;
  localparam int OUT_DIST_LSB = OUT_ID_LSB + ID_W;
  localparam int OUT_DATA_W   = 48;

  // sideband that follows a seed through the distance pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } dist_tag_t;

endpackage

// ===== rtl/core/nearest_seed_voronoi_labeler.sv =====
// ----------------------------------------------------------------------------
// nearest_seed_voronoi_labeler
// labels a lattice point with the nearest seed of a loaded seed table
// ----------------------------------------------------------------------------
//  channel  | handshake          | fields (low bit up)
//  s_       | s_tvalid/s_tready  | tuser: mode; tdata: seed_index, coord_x, coord_y
//  m_       | m_tvalid/m_tready  | tdata: nearest_id, min_distance, zero fill
//  cfg_     | cfg_valid/cfg_ready| cfg_data: seed_count
//
//  a load is written straight into the seed ram.
//  in a query one distance unit walks the seed ram one seed per cycle,
//  and the ram read port sets that pace.
//  s_tready is low during the search; a finished result waits in the output
//  register, and the block takes new words while it waits.
//  rst is synchronous; the seed ram has no reset and no clearing pass.
// ----------------------------------------------------------------------------
module nearest_seed_voronoi_labeler #(
  parameter int MAX_SEEDS  = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // mode
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic                               s_tuser,
  // seed_index, coord_x, coord_y
  input  logic [nsvl_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // nearest_id, min_distance, zero fill
  output logic [nsvl_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  // seed_count
  input  logic [nsvl_pkg::COUNT_W-1:0]       cfg_data
);

  localparam int AW  = $clog2(MAX_SEEDS);
  localparam int CW  = (COORD_BITS < nsvl_pkg::FIELD_W) ? COORD_BITS : nsvl_pkg::FIELD_W;
  localparam int DW  = 2 * CW + 1;
  localparam int XW  = (AW > nsvl_pkg::SLOT_W) ? AW : nsvl_pkg::SLOT_W;
  localparam int IDW = AW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                   state;
  logic [nsvl_pkg::COUNT_W-1:0] seed_count;
  logic [CW-1:0]                px;
  logic [CW-1:0]                py;
  logic [AW-1:0]                last_idx;
  logic [AW-1:0]                rd_addr;
  logic                         issuing;
  nsvl_pkg::dist_tag_t          rd_tag;
  nsvl_pkg::dist_tag_t          d_tag;
  logic [DW-1:0]                dist_sq;
  logic [AW-1:0]                cmp_idx;
  logic [DW-1:0]                best;
  logic [IDW-1:0]               best_id;
  logic [2*CW-1:0]              rdata;
  logic                         s_fire;
  logic                         load_fire;
  logic                         query_fire;
  logic                         slot_ok;
  logic [XW-1:0]                slot_ext;
  logic [CW-1:0]                in_x;
  logic [CW-1:0]                in_y;
  logic [31:0]                  cnt_lim;
  logic                         fin_load;

  // input word decode
  assign s_tready   = (state == ST_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign load_fire  = s_fire && (s_tuser == nsvl_pkg::MODE_LOAD);
  assign query_fire = s_fire && (s_tuser == nsvl_pkg::MODE_QUERY);
  assign in_x       = s_tdata[nsvl_pkg::IN_X_LSB +: CW];
  assign in_y       = s_tdata[nsvl_pkg::IN_Y_LSB +: CW];
  assign slot_ext   = XW'(s_tdata[nsvl_pkg::IN_SLOT_LSB +: nsvl_pkg::SLOT_W]);
  assign slot_ok    = (32'(s_tdata[nsvl_pkg::IN_SLOT_LSB +: nsvl_pkg::SLOT_W])
                       < 32'(MAX_SEEDS));

  // searched seed count, zero acts as one and large values saturate
  always_comb begin
    if (seed_count == '0) begin
      cnt_lim = 32'd1;
    end else if (32'(seed_count) > 32'(MAX_SEEDS)) begin
      cnt_lim = 32'(MAX_SEEDS);
    end else begin
      cnt_lim = 32'(seed_count);
    end
  end

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count <= nsvl_pkg::COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      seed_count <= cfg_data;
    end
  end

  // seed table, x in the low half and y in the high half
  nsvl_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_SEEDS)
  ) u_seed_ram (
    .clk   (clk),
    .we    (load_fire && slot_ok),
    .waddr (slot_ext[AW-1:0]),
    .wdata ({in_y, in_x}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // query point latch
  always_ff @(posedge clk) begin
    if (query_fire) begin
      px       <= in_x;
      py       <= in_y;
      last_idx <= AW'(cnt_lim - 32'd1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (query_fire) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (d_tag.vld && d_tag.last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // read address walk, one seed per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_tag  <= '0;
      rd_addr <= '0;
    end else if (query_fire) begin
      issuing <= 1'b1;
      rd_tag  <= '0;
      rd_addr <= '0;
    end else begin
      rd_tag.vld   <= issuing;
      rd_tag.first <= (rd_addr == '0);
      rd_tag.last  <= (rd_addr == last_idx);
      if (issuing) begin
        rd_addr <= rd_addr + AW'(1);
        if (rd_addr == last_idx) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  // shared distance unit
  nsvl_dist #(
    .CW (CW)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (rd_tag),
    .px      (px),
    .py      (py),
    .sx      (rdata[CW-1:0]),
    .sy      (rdata[2*CW-1:CW]),
    .tag_out (d_tag),
    .dist_sq (dist_sq)
  );

  // running minimum, strict less keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (query_fire) begin
      cmp_idx <= '0;
    end else if (d_tag.vld) begin
      cmp_idx <= cmp_idx + AW'(1);
      if (d_tag.first || (dist_sq < best)) begin
        best    <= dist_sq;
        best_id <= IDW'(cmp_idx) + IDW'(1);
      end
    end
  end

  // output register
  assign fin_load = (state == ST_FIN) && (!m_tvalid || m_tready);
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result word, zero fill above the distance
  always_ff @(posedge clk) begin
    if (fin_load) begin
      m_tdata <= nsvl_pkg::OUT_DATA_W'({nsvl_pkg::DIST_W'(best), nsvl_pkg::ID_W'(best_id)});
    end
  end

endmodule

// ===== rtl/core/nsvl_ram.sv =====
// ----------------------------------------------------------------------------
// nsvl_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module nsvl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/nsvl_dist.sv =====
// ----------------------------------------------------------------------------
// nsvl_dist
// pipelined squared distance unit: absolute differences, then squares
// ----------------------------------------------------------------------------
module nsvl_dist #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nsvl_pkg::dist_tag_t  tag_in,
  input  logic [CW-1:0]        px,
  input  logic [CW-1:0]        py,
  input  logic [CW-1:0]        sx,
  input  logic [CW-1:0]        sy,
  output nsvl_pkg::dist_tag_t  tag_out,
  output logic [2*CW:0]        dist_sq
);

  nsvl_pkg::dist_tag_t tag_d;
  nsvl_pkg::dist_tag_t tag_q;
  logic [CW-1:0]       ax;
  logic [CW-1:0]       ay;
  logic [2*CW-1:0]     sqx;
  logic [2*CW-1:0]     sqy;

  // tag valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d <= '0;
      tag_q <= '0;
    end else begin
      tag_d <= tag_in;
      tag_q <= tag_d;
    end
  end

  // stage one: absolute differences
  always_ff @(posedge clk) begin
    ax <= (px >= sx) ? (px - sx) : (sx - px);
    ay <= (py >= sy) ? (py - sy) : (sy - py);
  end

  // stage two: squares
  always_ff @(posedge clk) begin
    sqx <= ax * ax;
    sqy <= ay * ay;
  end

  // the sum feeds the running minimum compare in the top level
  assign dist_sq = {1'b0, sqx} + {1'b0, sqy};
  assign tag_out = tag_q;

endmodule

// ===== rtl/core/nsvl_checker.sv =====
// ----------------------------------------------------------------------------
// nsvl_checker
// port level checks of the nearest seed voronoi labeler, bound to the top
// ----------------------------------------------------------------------------
`include "nearest_seed_voronoi_labeler_defines.svh"

module nsvl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic [nsvl_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [nsvl_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [nsvl_pkg::COUNT_W-1:0]    cfg_data
);

  // a stalled result word holds
  `NSVL_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // an accepted query lowers s_tready, blocking the input for its search
  `NSVL_ASSERT(a_query_busy, clk, rst, s_tvalid && s_tready && s_tuser == nsvl_pkg::MODE_QUERY |=> !s_tready)

  // a query cannot produce its result in the next cycle
  `NSVL_ASSERT(a_no_instant, clk, rst, s_tvalid && s_tready && s_tuser == nsvl_pkg::MODE_QUERY && !m_tvalid |=> !m_tvalid)

  // a new result appears only as the block turns idle again
  `NSVL_NEVER(a_rise_idle, clk, rst, $rose(m_tvalid) && !s_tready)

endmodule

bind nearest_seed_voronoi_labeler nsvl_checker u_nsvl_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tuser   (s_tuser),
  .s_tdata   (s_tdata),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);
